// ===== hw/rtl/hed_pkg.sv =====
// Shared types, character codes and digit helpers for the hex escape decoder.
package hed_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam int RES_MAX = 3;

  typedef logic [7:0]  char_t;
  typedef logic [15:0] word_t;

  // Results produced by one input beat; v[0] goes out first.
  typedef struct packed {
    logic [1:0]              n;
    logic [RES_MAX-1:0][15:0] v;
  } res_t;

  function automatic logic is_alnum(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_hex(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input char_t c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic word_t sext8(input char_t c);
    return {{8{c[7]}}, c};
  endfunction

  // Leading hex digits of the first k of up to four characters, after an optional 0x or 0X.
  function automatic word_t digits_value(input logic [3:0][7:0] d, input logic [2:0] k);
    logic       skip;
    logic       stop;
    logic [2:0] start;
    word_t      v;
    skip  = (k >= 3'd3) && (d[0] == CH_ZERO) && (d[1] == CH_X_LO || d[1] == CH_X_UP) &&
            is_hex(d[2]);
    start = skip ? 3'd2 : 3'd0;
    stop  = 1'b0;
    v     = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) >= start && 3'(i) < k && !stop) begin
        if (is_hex(d[i])) v = {v[11:0], hex_nib(d[i])};
        else stop = 1'b1;
      end
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/hed_parse.sv =====
// Escape parser: phase register, held digits and the per-beat result decode.
module hed_parse #(
  parameter int MAX_DIGITS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     c,
  input  logic           eos,
  output hed_pkg::res_t  res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SLASH = 3'd1;
  localparam logic [2:0] PH_DIG0  = 3'd2;
  localparam logic [2:0] PH_LAST  = 3'(2 + MAX_DIGITS - 1);
  localparam int HELD_DEPTH = (MAX_DIGITS > 1) ? MAX_DIGITS - 1 : 1;

  logic [2:0] phase, phase_next;
  logic [7:0] held_digits [HELD_DEPTH];
  logic       hold_wr;
  logic [2:0] held;
  logic [3:0][7:0] hd4, buf4;

  assign held = phase - PH_DIG0;

  always_comb begin
    hd4 = '0;
    for (int i = 0; i < HELD_DEPTH; i++) hd4[i] = held_digits[i];
    buf4 = hd4;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) == held) buf4[i] = c;
    end
  end

  always_comb begin
    res        = '0;
    phase_next = phase;
    hold_wr    = 1'b0;
    if (phase == PH_SLASH) begin
      if (c == hed_pkg::CH_X_LO) begin
        phase_next = PH_DIG0;
      end else begin
        res.n      = 2'd2;
        res.v[0]   = hed_pkg::sext8(hed_pkg::CH_BSLASH);
        res.v[1]   = hed_pkg::sext8(c);
        phase_next = PH_IDLE;
      end
    end else if (phase >= PH_DIG0) begin
      if (hed_pkg::is_alnum(c)) begin
        if (({1'b0, held} + 4'd1) >= 4'(MAX_DIGITS)) begin
          res.n      = 2'd1;
          res.v[0]   = hed_pkg::digits_value(buf4, held + 3'd1);
          phase_next = PH_IDLE;
        end else begin
          hold_wr    = 1'b1;
          phase_next = phase + 3'd1;
        end
      end else if (held == 3'd0) begin
        // "\x" with no digit: give the characters back
        res.n      = 2'd3;
        res.v[0]   = hed_pkg::sext8(hed_pkg::CH_BSLASH);
        res.v[1]   = hed_pkg::sext8(hed_pkg::CH_X_LO);
        res.v[2]   = hed_pkg::sext8(c);
        phase_next = PH_IDLE;
      end else begin
        res.v[0] = hed_pkg::digits_value(hd4, held);
        if (c == hed_pkg::CH_BSLASH) begin
          res.n      = 2'd1;
          phase_next = PH_SLASH;
        end else begin
          res.n      = 2'd2;
          res.v[1]   = hed_pkg::sext8(c);
          phase_next = PH_IDLE;
        end
      end
    end else begin
      if (c == hed_pkg::CH_BSLASH) begin
        phase_next = PH_SLASH;
      end else begin
        res.n    = 2'd1;
        res.v[0] = hed_pkg::sext8(c);
      end
    end
    if (eos) phase_next = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HELD_DEPTH; i++) begin
      if (step && hold_wr && held == 3'(i)) held_digits[i] <= c;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk) disable iff (rst) phase <= PH_LAST)
    else $error("phase out of range");
  a_eos_idle: assert property (@(posedge clk) disable iff (rst) (step && eos) |=> phase == PH_IDLE)
    else $error("phase not idle after end of string");
`endif

endmodule

// ===== hw/rtl/hed_emit.sv =====
// Result buffer: holds up to three results of one beat and sends them one per cycle while m_tready is high.
module hed_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  hed_pkg::res_t  res,
  output logic           can_load,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata,   // [15:0] out_value
  output logic           m_tlast
);

  logic [1:0] rem;
  logic [hed_pkg::RES_MAX-1:0][15:0] vals;
  logic       take;

  assign m_tvalid = rem != 2'd0;
  assign take     = m_tvalid && m_tready;
  assign m_tdata  = vals[0];
  assign m_tlast  = rem == 2'd1;
  // Refill only once the last pending result leaves
  assign can_load = (rem == 2'd0) || (rem == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= res.n;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vals <= res.v;
    end else if (take) begin
      vals <= {16'h0000, vals[hed_pkg::RES_MAX-1:1]};
    end
  end

`ifndef NO_ASSERTIONS
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
      load |-> (rem == 2'd0 || (rem == 2'd1 && m_tready)))
    else $error("result buffer overwritten");
  a_rem_step: assert property (@(posedge clk) disable iff (rst)
      (take && !load) |=> rem == $past(rem) - 2'd1)
    else $error("result count inconsistent");
`endif

endmodule

// ===== hw/rtl/hex_escape_decoder.sv =====
// An accepted beat waits in the input register until the result buffer can take it.
// Throughput: one beat per cycle while m_tready is high and each beat yields at most
// one result; a beat with several results holds the parse stage until its last leaves.
// The three-entry result buffer and the input register set this rate.
// Reset (rst, synchronous) empties both registers and returns the parser to idle.
module hex_escape_decoder #(
  parameter int MAX_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] out_value
  output logic        m_tlast    // last_of_run
);

  logic          in_full;
  logic [7:0]    in_c;
  logic          in_eos;
  logic          can_load;
  logic          consume;
  logic          s_take;
  hed_pkg::res_t res;

  assign consume  = in_full && can_load;
  assign s_tready = !in_full || consume;
  assign s_take   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_take) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_c   <= s_tdata;
      in_eos <= s_tlast;
    end
  end

  hed_parse #(.MAX_DIGITS(MAX_DIGITS)) u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (consume),
    .c    (in_c),
    .eos  (in_eos),
    .res  (res)
  );

  hed_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (consume),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (rst) !s_tready |-> in_full)
    else $error("input stalled while register empty");
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
      (in_full && !consume) |=> (in_full && $stable(in_c) && $stable(in_eos)))
    else $error("pending beat lost");
`endif

endmodule
